// ===== hw/rtl/running_mean_variance_assert.svh =====
// Assertion macros shared by the running mean and variance modules.
`ifndef RUNNING_MEAN_VARIANCE_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define RMV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running_mean_variance: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define RMV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running_mean_variance: next-cycle check failed");

`endif

// ===== hw/rtl/rmv_pkg.sv =====
// Shared types, constants and command/status structs for running_mean_variance.
package rmv_pkg;

    // Default sizes of the statistics state
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 32;

    // Fixed field widths
    localparam int SAMPLE_FIELD_W = 32;
    localparam int CODE_W         = 8;
    localparam int COUNT_FIELD_W  = 32;
    localparam int MEAN_FIELD_W   = 32;
    localparam int SUM_W          = 64;
    localparam int VAR_W          = 63;
    localparam int STATUS_W       = 2;

    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    // Stream packing
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 3;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] CFG_PRESENT_CODE = 1'b0;
    localparam logic [CODE_W-1:0]     PRESENT_CODE_RST = 8'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_ERROR   = 2'd2,
        ST_LATCHED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_MDIV,
        S_MEND,
        S_MUL,
        S_VAR,
        S_VDIV,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    set_status;
        t_status status;
        logic    latch_err;
        logic    add_start;
        logic    mean_apply;
        logic    mul_start;
        logic    sum_apply;
        logic    vdiv_start;
        logic    var_zero;
        logic    var_apply;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic err;
        logic match;
        logic finite;
        logic full;
        logic cnt_zero;
        logic div_busy;
        logic div_done;
        logic mul_done;
        logic sum_over;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/running_mean_variance.sv =====
// Top level: stream and configuration ports around the Welford statistics engine.
//
// Input stream (s_axis): one sample per item with its presence code in tdata and
// the finite and first-of-set flags in tuser. Output stream (m_axis): one result
// per item with the count, mean and population variance in tdata, and the
// variance-valid flag and the status code in tuser.
// Configuration: APB-style port, present_code at byte address 0, reset value 1.
// Items are processed one at a time. A counted sample goes through the shared
// radix-2 divider (SAMPLE_WIDTH+1 steps for the mean, 64 steps for the
// variance) and the bit-serial multiplier (SAMPLE_WIDTH+1 steps), each
// retiring one bit per cycle.
// A finished result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, the following item completes and holds in
// the engine until the output register frees up, and s_axis_tready stays low.
// Reset clears the count, mean, sum, error flag and the output valid flag, and
// returns present_code to 1.
module running_mean_variance
    import rmv_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // sample_value[31:0], presence_code[39:32]
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,   // sample_finite[0], first_of_set[1]
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // present_count[31:0], mean_value[63:32],
                                                  // variance_value[126:64], zero[127]
    output logic [M_TUSER_W-1:0]  m_axis_tuser    // variance_valid[0], status[2:1]
);

    logic [CODE_W-1:0]        r_present_code;
    logic                     cfg_we;
    logic                     cfg_hit;

    t_dp_cmd                  dp_cmd;
    t_dp_stat                 dp_stat;
    logic [COUNT_FIELD_W-1:0] out_count;
    logic [MEAN_FIELD_W-1:0]  out_mean;
    logic [VAR_W-1:0]         out_var;
    logic                     out_vvalid;
    t_status                  out_status;

    // Decode configuration writes and reads
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == CFG_PRESENT_CODE);
    assign cfg_we  = psel && penable && pwrite && pready;
    assign prdata  = cfg_hit ? APB_DATA_W'(r_present_code) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present_code <= PRESENT_CODE_RST;
        end else if (cfg_we && cfg_hit) begin
            r_present_code <= pwdata[CODE_W-1:0];
        end
    end

    rmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    rmv_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_sample_value   (s_axis_tdata[SAMPLE_FIELD_W-1:0]),
        .i_presence_code  (s_axis_tdata[SAMPLE_FIELD_W+CODE_W-1:SAMPLE_FIELD_W]),
        .i_sample_finite  (s_axis_tuser[0]),
        .i_first_of_set   (s_axis_tuser[1]),
        .i_present_code   (r_present_code),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_present_count  (out_count),
        .o_mean_value     (out_mean),
        .o_variance_value (out_var),
        .o_variance_valid (out_vvalid),
        .o_status         (out_status)
    );

    // Pack the result item
    assign m_axis_tdata = {1'b0, out_var, out_mean, out_count};
    assign m_axis_tuser = {out_status, out_vvalid};

endmodule

// ===== hw/rtl/rmv_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module rmv_divider
    import rmv_pkg::*;
#(
    parameter int   DIVIDEND_WIDTH = SUM_W,
    parameter int   DIVISOR_WIDTH  = COUNT_WIDTH_DEF,
    localparam int  ITER_W         = $clog2(DIVIDEND_WIDTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DIVIDEND_WIDTH-1:0] i_dividend,
    input  logic [DIVISOR_WIDTH-1:0]  i_divisor,
    input  logic [ITER_W-1:0]         i_iters,
    output logic [DIVIDEND_WIDTH-1:0] o_quotient,
    output logic                      o_busy,
    output logic                      o_done
);

    logic [DIVISOR_WIDTH-1:0]  r_rem;
    logic [DIVIDEND_WIDTH-1:0] r_quo;
    logic [DIVISOR_WIDTH-1:0]  r_div;
    logic [ITER_W-1:0]         r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [DIVISOR_WIDTH:0]    trial;
    logic [DIVISOR_WIDTH:0]    diff;
    logic                      ge;
    logic [DIVISOR_WIDTH-1:0]  n_rem;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_WIDTH-1]};
        ge    = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
        n_rem = ge ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
    end

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_iters;
        end else begin
            r_done <= r_busy && (r_cnt == ITER_W'(1));
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_WIDTH-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

// ===== hw/rtl/rmv_multiplier.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module rmv_multiplier
    import rmv_pkg::*;
#(
    parameter int  OPERAND_WIDTH = SAMPLE_WIDTH_DEF + 1,
    localparam int ITER_W        = $clog2(OPERAND_WIDTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [OPERAND_WIDTH-1:0]     i_a,
    input  logic [OPERAND_WIDTH-1:0]     i_b,
    output logic [2*OPERAND_WIDTH-1:0]   o_product,
    output logic                         o_done
);

    logic [OPERAND_WIDTH-1:0] r_a;
    logic [OPERAND_WIDTH-1:0] r_hi;
    logic [OPERAND_WIDTH-1:0] r_lo;
    logic [ITER_W-1:0]        r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [OPERAND_WIDTH:0]   psum;

    // Add the multiplicand when the current multiplier bit is set
    assign psum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= ITER_W'(OPERAND_WIDTH);
        end else begin
            r_done <= r_busy && (r_cnt == ITER_W'(1));
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Partial product shifts right one bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= psum[OPERAND_WIDTH:1];
            r_lo <= {psum[0], r_lo[OPERAND_WIDTH-1:1]};
        end
    end

    assign o_product = {r_hi, r_lo};
    assign o_done    = r_done;

endmodule

// ===== hw/rtl/rmv_datapath.sv =====
// Statistics state, arithmetic units and result register.
`include "running_mean_variance_assert.svh"
module rmv_datapath
    import rmv_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic [SAMPLE_FIELD_W-1:0] i_sample_value,
    input  logic [CODE_W-1:0]         i_presence_code,
    input  logic                      i_sample_finite,
    input  logic                      i_first_of_set,
    input  logic [CODE_W-1:0]         i_present_code,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [COUNT_FIELD_W-1:0]  o_present_count,
    output logic [MEAN_FIELD_W-1:0]   o_mean_value,
    output logic [VAR_W-1:0]          o_variance_value,
    output logic                      o_variance_valid,
    output t_status                   o_status
);

    localparam int MUL_W      = SAMPLE_WIDTH + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int PROD_EXT_W = (PROD_W > SUM_W) ? PROD_W : SUM_W + 1;
    localparam int MEAN_SHIFT = SUM_W - MUL_W;
    localparam int DIV_ITER_W = $clog2(SUM_W + 1);
    localparam int RAW_W      = SAMPLE_WIDTH + SAMPLE_FIELD_W;
    localparam int MEAN_EXT_W = SAMPLE_WIDTH + MEAN_FIELD_W;

    // Statistics state
    logic [COUNT_WIDTH-1:0]         r_count;
    logic signed [SAMPLE_WIDTH-1:0] r_mean;
    logic [SUM_W-1:0]               r_sum;
    logic                           r_err;

    // Item and working registers
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic [CODE_W-1:0]              r_code;
    logic                           r_finite;
    logic [MUL_W-1:0]               r_abs_delta;
    logic                           r_delta_neg;
    t_status                        r_status;
    logic [VAR_W-1:0]               r_var;

    // Result register
    logic                           r_out_valid;
    logic [COUNT_FIELD_W-1:0]       r_out_count;
    logic [MEAN_FIELD_W-1:0]        r_out_mean;
    logic [VAR_W-1:0]               r_out_var;
    logic                           r_out_vvalid;
    t_status                        r_out_status;

    logic [RAW_W-1:0]               raw_sample;
    logic signed [MUL_W-1:0]        delta;
    logic [MUL_W-1:0]               abs_delta;
    logic [MUL_W-1:0]               quo_mag;
    logic [MUL_W-1:0]               quo_signed;
    logic [MUL_W-1:0]               mean_new;
    logic signed [MEAN_EXT_W-1:0]   mean_wide;

    logic                           div_start;
    logic [SUM_W-1:0]               div_dividend;
    logic [COUNT_WIDTH-1:0]         div_divisor;
    logic [DIV_ITER_W-1:0]          div_iters;
    logic [SUM_W-1:0]               div_quo;
    logic                           div_busy;
    logic                           div_done;

    logic [PROD_W-1:0]              mul_prod;
    logic                           mul_done;
    logic [PROD_EXT_W-1:0]          prod_ext;
    logic                           prod_over;
    logic [SUM_W:0]                 sum_ext;
    logic                           sum_over;

    // Take the low sample bits; the sample field is zero-extended, not sign-extended
    assign raw_sample = RAW_W'(i_sample_value);

    // Deviation from the current mean and its magnitude
    assign delta     = MUL_W'(r_x) - MUL_W'(r_mean);
    assign abs_delta = delta[MUL_W-1] ? MUL_W'(-delta) : MUL_W'(delta);

    // Signed mean step from the divider quotient
    assign quo_mag    = div_quo[MUL_W-1:0];
    assign quo_signed = r_delta_neg ? (~quo_mag + 1'b1) : quo_mag;
    assign mean_new   = MUL_W'(r_mean) + quo_signed;
    assign mean_wide  = MEAN_EXT_W'(r_mean);

    // Shared divider: mean step first, then the variance
    assign div_start    = i_cmd.add_start | i_cmd.vdiv_start;
    assign div_dividend = i_cmd.add_start ? (SUM_W'(abs_delta) << MEAN_SHIFT) : r_sum;
    assign div_divisor  = i_cmd.add_start ? COUNT_WIDTH'(r_count + 1'b1) : r_count;
    assign div_iters    = i_cmd.add_start ? DIV_ITER_W'(MUL_W) : DIV_ITER_W'(SUM_W);

    rmv_divider #(
        .DIVIDEND_WIDTH (SUM_W),
        .DIVISOR_WIDTH  (COUNT_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_iters    (div_iters),
        .o_quotient (div_quo),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    // Old deviation times new deviation
    rmv_multiplier #(
        .OPERAND_WIDTH (MUL_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.mul_start),
        .i_a       (r_abs_delta),
        .i_b       (abs_delta),
        .o_product (mul_prod),
        .o_done    (mul_done)
    );

    // Accumulate with overflow detection
    assign prod_ext  = PROD_EXT_W'(mul_prod);
    assign prod_over = |prod_ext[PROD_EXT_W-1:SUM_W];
    assign sum_ext   = {1'b0, r_sum} + {1'b0, prod_ext[SUM_W-1:0]};
    assign sum_over  = prod_over | sum_ext[SUM_W];

    // Statistics state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mean  <= '0;
            r_sum   <= '0;
            r_err   <= 1'b0;
        end else begin
            if (i_cmd.load && i_first_of_set) begin
                r_count <= '0;
                r_mean  <= '0;
                r_sum   <= '0;
                r_err   <= 1'b0;
            end
            if (i_cmd.latch_err) begin
                r_err <= 1'b1;
            end
            if (i_cmd.add_start) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.mean_apply) begin
                r_mean <= mean_new[SAMPLE_WIDTH-1:0];
            end
            if (i_cmd.sum_apply) begin
                r_sum <= sum_over ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                if (sum_over) begin
                    r_err <= 1'b1;
                end
            end
        end
    end

    // Item capture and working values
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x      <= raw_sample[SAMPLE_WIDTH-1:0];
            r_code   <= i_presence_code;
            r_finite <= i_sample_finite;
        end
        if (i_cmd.add_start) begin
            r_abs_delta <= abs_delta;
            r_delta_neg <= delta[MUL_W-1];
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.var_zero) begin
            r_var <= '0;
        end else if (i_cmd.var_apply) begin
            r_var <= div_quo[SUM_W-1] ? VAR_MAX : div_quo[VAR_W-1:0];
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count  <= COUNT_FIELD_W'(r_count);
            r_out_mean   <= mean_wide[MEAN_FIELD_W-1:0];
            r_out_var    <= r_var;
            r_out_vvalid <= (|r_count) && !r_err;
            r_out_status <= r_status;
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat          = '0;
        o_stat.err      = r_err;
        o_stat.match    = (r_code == i_present_code);
        o_stat.finite   = r_finite;
        o_stat.full     = &r_count;
        o_stat.cnt_zero = ~|r_count;
        o_stat.div_busy = div_busy;
        o_stat.div_done = div_done;
        o_stat.mul_done = mul_done;
        o_stat.sum_over = sum_over;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_present_count  = r_out_count;
    assign o_mean_value     = r_out_mean;
    assign o_variance_value = r_out_var;
    assign o_variance_valid = r_out_vvalid;
    assign o_status         = r_out_status;

    `RMV_ASSERT_NXT(a_sum_saturates, i_clk, i_rst_n, i_cmd.sum_apply && sum_over, r_err && (&r_sum))
    `RMV_ASSERT_NXT(a_first_clears, i_clk, i_rst_n, i_cmd.load && i_first_of_set, (r_count == '0) && !r_err)
    `RMV_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || i_out_ready)

endmodule

// ===== hw/rtl/rmv_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`include "running_mean_variance_assert.svh"
module rmv_ctrl
    import rmv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.set_status = 1'b1;
                if (i_stat.err) begin
                    o_cmd.status = ST_LATCHED;
                    n_state      = S_VAR;
                end else if (!i_stat.match) begin
                    o_cmd.status = ST_SKIPPED;
                    n_state      = S_VAR;
                end else if (!i_stat.finite || i_stat.full) begin
                    o_cmd.status    = ST_ERROR;
                    o_cmd.latch_err = 1'b1;
                    n_state         = S_VAR;
                end else begin
                    // Count the sample and start the mean step division
                    o_cmd.set_status = 1'b0;
                    o_cmd.add_start  = 1'b1;
                    n_state          = S_MDIV;
                end
            end
            S_MDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.mean_apply = 1'b1;
                    n_state          = S_MEND;
                end
            end
            S_MEND: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.sum_apply  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = i_stat.sum_over ? ST_ERROR : ST_ADDED;
                    n_state          = S_VAR;
                end
            end
            S_VAR: begin
                if (i_stat.cnt_zero) begin
                    o_cmd.var_zero = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.vdiv_start = 1'b1;
                    n_state          = S_VDIV;
                end
            end
            S_VDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.var_apply = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the result register can take the item
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `RMV_ASSERT_NXT(a_accept_eval, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid, r_state == S_EVAL)
    `RMV_ASSERT_IMP(a_div_free, i_clk, i_rst_n, o_cmd.add_start || o_cmd.vdiv_start, !i_stat.div_busy)

endmodule
